[sv/gopd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gopd_pkg
// Shared types and constants of the glyph outline point decoder.
// ----------------------------------------------------------------------------
package gopd_pkg;
   localparam int MaxPoints = 64;
   localparam int IdxW = 6;
   localparam int CntW = 7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ENDPTS, ST_INSTLEN, ST_INSTSKIP, ST_FLAGS, ST_REPEAT,
      ST_FILL, ST_XDELTA, ST_YDELTA, ST_FREE, ST_EMIT, ST_ERROR
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic start;       // clear counters, load contour count
      logic take_high;   // latch high byte of a word
      logic endpt_word;  // end-point word completed
      logic instlen_word;
      logic skip_dec;
      logic flag_write;  // store the flag byte at the cursor
      logic repeat_load; // load repeat count
      logic fill_step;   // write one repeated flag
      logic begin_coords;
      logic delta_byte;  // apply short delta
      logic delta_word;  // apply word delta
      logic close_pt;    // store x or queue a point
      logic is_x;
      logic emit_err;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic endpts_done;  // last end-point word arriving
      logic too_many;
      logic inst_zero;
      logic skip_done;
      logic flag_rep;     // flag byte has repeat bit
      logic flags_full;   // cursor reaches total after this flag
      logic rep_overrun;
      logic rep_zero;
      logic fill_done;
      logic cur_short;    // current flag: short delta
      logic cur_free;     // current flag: no byte
      logic last_cursor;  // cursor + 1 reaches total
      logic hi_pending;
   } sts_type;
endpackage
`default_nettype wire

[sv/gopd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gopd_datapath
// Counters, stores and coordinate accumulator of the point decoder.
// ----------------------------------------------------------------------------
module gopd_datapath import gopd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   input  wire logic [7:0]        data_byte,
   input  wire logic [14:0]       contour_count,
   output sts_type                sts,
   output logic signed [15:0]     x_coord,
   output logic signed [15:0]     y_coord,
   output logic [IdxW-1:0]        point_number,
   output logic                   last_point
);
   logic [15:0]     bytes_left_ff;
   logic            hi_pending_ff;
   logic [7:0]      high_byte_ff;
   logic [CntW-1:0] total_ff, cursor_ff, fill_left_ff;
   logic [5:0]      held_flag_ff;
   logic [15:0]     run_ff;
   logic [5:0]      flag_store [MaxPoints];
   logic [15:0]     x_store [MaxPoints];
   logic [5:0]      cur_flag_ff;
   logic [15:0]     x_rd_ff;
   logic [15:0]     word, run_in;
   logic [CntW-1:0] cursor_in;
   logic [8:0]      rep_sum;
   logic [IdxW-1:0] rd_addr;

   assign word = {high_byte_ff, data_byte};
   assign rep_sum = {2'b0, cursor_ff} + {1'b0, data_byte};

   always_comb begin
      run_in = run_ff;
      if (cmd.delta_byte) begin
         if (cmd.is_x ? cur_flag_ff[4] : cur_flag_ff[5])
            run_in = run_ff + {8'd0, data_byte};
         else
            run_in = run_ff - {8'd0, data_byte};
      end else if (cmd.delta_word) begin
         run_in = run_ff + word;
      end
   end

   assign cursor_in = cursor_ff + CntW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_pending_ff <= 1'b0;
         cursor_ff <= '0;
         total_ff <= '0;
         bytes_left_ff <= '0;
         fill_left_ff <= '0;
      end else begin
         if (cmd.start) begin
            hi_pending_ff <= 1'b0;
            cursor_ff <= '0;
            total_ff <= '0;
            run_ff <= '0;
            bytes_left_ff <= {1'b0, contour_count};
         end
         if (cmd.take_high) begin
            high_byte_ff <= data_byte;
            hi_pending_ff <= 1'b1;
         end
         if (cmd.endpt_word) begin
            hi_pending_ff <= 1'b0;
            bytes_left_ff <= bytes_left_ff - 16'd1;
            total_ff <= CntW'(word[IdxW-1:0]) + CntW'(1);
         end
         if (cmd.instlen_word) begin
            hi_pending_ff <= 1'b0;
            bytes_left_ff <= word;
            cursor_ff <= '0;
         end
         if (cmd.skip_dec) bytes_left_ff <= bytes_left_ff - 16'd1;
         if (cmd.flag_write) begin
            held_flag_ff <= data_byte[5:0];
            flag_store[cursor_ff[IdxW-1:0]] <= data_byte[5:0];
            if (!data_byte[3]) cursor_ff <= cursor_in;
         end
         if (cmd.repeat_load) begin
            fill_left_ff <= CntW'(data_byte);
            cursor_ff <= cursor_in;
         end
         if (cmd.fill_step) begin
            flag_store[cursor_ff[IdxW-1:0]] <= held_flag_ff;
            fill_left_ff <= fill_left_ff - CntW'(1);
            cursor_ff <= cursor_in;
         end
         if (cmd.begin_coords) begin
            cursor_ff <= '0;
            run_ff <= '0;
            hi_pending_ff <= 1'b0;
         end
         if (cmd.delta_byte || cmd.delta_word) run_ff <= run_in;
         if (cmd.delta_word) hi_pending_ff <= 1'b0;
         if (cmd.close_pt) begin
            if (cmd.is_x) x_store[cursor_ff[IdxW-1:0]] <= run_in;
            x_coord <= x_rd_ff;
            y_coord <= run_in;
            point_number <= cursor_ff[IdxW-1:0];
            last_point <= (cursor_in == total_ff);
            if (cmd.is_x && cursor_in >= total_ff) begin
               cursor_ff <= '0;
               run_ff <= '0;
            end else begin
               cursor_ff <= cursor_in;
            end
         end
         if (cmd.emit_err) begin
            x_coord <= '0;
            y_coord <= '0;
            point_number <= '0;
            last_point <= 1'b0;
         end
      end
   end

   // Entry that becomes current at this edge: the first point when the
   // coordinates begin or the x pass wraps, the next point after a close.
   always_comb begin
      rd_addr = cursor_ff[IdxW-1:0];
      if (cmd.begin_coords || (cmd.close_pt && cmd.is_x && cursor_in >= total_ff))
         rd_addr = '0;
      else if (cmd.close_pt)
         rd_addr = cursor_in[IdxW-1:0];
   end

   // Registered store reads; a write to the same entry in this cycle is
   // passed straight through.
   always_ff @(posedge clock) begin
      if (cmd.flag_write && cursor_ff[IdxW-1:0] == rd_addr)
         cur_flag_ff <= data_byte[5:0];
      else if (cmd.fill_step && cursor_ff[IdxW-1:0] == rd_addr)
         cur_flag_ff <= held_flag_ff;
      else
         cur_flag_ff <= flag_store[rd_addr];
      if (cmd.close_pt && cmd.is_x && cursor_ff[IdxW-1:0] == rd_addr)
         x_rd_ff <= run_in;
      else
         x_rd_ff <= x_store[rd_addr];
   end

   always_comb begin
      sts.endpts_done = (bytes_left_ff == 16'd1);
      sts.too_many = (word >= 16'(MaxPoints));
      sts.inst_zero = (word == 16'd0);
      sts.skip_done = (bytes_left_ff == 16'd1);
      sts.flag_rep = data_byte[3];
      sts.flags_full = (cursor_in >= total_ff);
      sts.rep_overrun = (rep_sum >= {2'b0, total_ff});
      sts.rep_zero = (data_byte == 8'd0);
      sts.fill_done = (fill_left_ff == CntW'(1)) || (fill_left_ff == '0);
      sts.cur_short = cmd.is_x ? cur_flag_ff[1] : cur_flag_ff[2];
      sts.cur_free = !sts.cur_short && (cmd.is_x ? cur_flag_ff[4] : cur_flag_ff[5]);
      sts.last_cursor = (cursor_in >= total_ff);
      sts.hi_pending = hi_pending_ff;
   end
endmodule
`default_nettype wire

[sv/gopd_control.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gopd_control
// Parse state machine and stream handshake of the point decoder.
// ----------------------------------------------------------------------------
module gopd_control import gopd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  in_valid,
   input  wire logic  glyph_start,
   input  wire logic  contour_zero,
   output logic       in_ready,
   output logic       out_valid,
   input  wire logic  out_ready,
   output logic       out_bad,
   input  wire sts_type sts,
   output cmd_type    cmd
);
   state_type state_ff, state_in, phase_ff, phase_in;
   logic      valid_ff, valid_in, bad_ff, bad_in;
   logic      acc;
   logic      xph;

   assign xph = (phase_ff == ST_XDELTA);
   assign in_ready = !valid_ff && (state_ff != ST_FILL) && (state_ff != ST_FREE);
   assign acc = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_bad = bad_ff;

   // Effective phase: a start byte restarts the parser.
   state_type eff;
   always_comb begin
      eff = state_ff;
      if (acc && glyph_start) eff = contour_zero ? ST_IDLE : ST_ENDPTS;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      valid_in = valid_ff && !out_ready;
      bad_in = bad_ff;
      cmd = '0;
      cmd.is_x = xph;
      if (acc && glyph_start) cmd.start = 1'b1;
      unique case (state_ff)
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_done) begin
               if (sts.flags_full) begin
                  cmd.begin_coords = 1'b1;
                  phase_in = ST_XDELTA;
                  state_in = ST_FREE;
               end else state_in = ST_FLAGS;
            end
         end
         ST_FREE: begin
            if (phase_ff == ST_IDLE) state_in = ST_IDLE;
            else if (sts.cur_free) begin
               cmd.close_pt = 1'b1;
               if (!xph) begin
                  valid_in = 1'b1; bad_in = 1'b0;
                  state_in = ST_EMIT;
                  if (sts.last_cursor) phase_in = ST_IDLE;
               end else if (sts.last_cursor) phase_in = ST_YDELTA;
            end else state_in = phase_ff;
         end
         ST_EMIT: if (!valid_ff || out_ready) state_in = ST_FREE;
         default: begin
            if (acc) begin
               state_in = eff;
               unique case (eff)
                  ST_ENDPTS, ST_INSTLEN: begin
                     if (!sts.hi_pending || glyph_start) cmd.take_high = 1'b1;
                     else if (eff == ST_ENDPTS) begin
                        cmd.endpt_word = 1'b1;
                        if (sts.endpts_done) begin
                           if (sts.too_many) begin
                              valid_in = 1'b1; bad_in = 1'b1;
                              cmd.emit_err = 1'b1; state_in = ST_IDLE;
                           end else state_in = ST_INSTLEN;
                        end
                     end else begin
                        cmd.instlen_word = 1'b1;
                        state_in = sts.inst_zero ? ST_FLAGS : ST_INSTSKIP;
                     end
                  end
                  ST_INSTSKIP: begin
                     cmd.skip_dec = 1'b1;
                     if (sts.skip_done) state_in = ST_FLAGS;
                  end
                  ST_FLAGS: begin
                     cmd.flag_write = 1'b1;
                     if (sts.flag_rep) state_in = ST_REPEAT;
                     else if (sts.flags_full) begin
                        cmd.begin_coords = 1'b1;
                        phase_in = ST_XDELTA; state_in = ST_FREE;
                     end
                  end
                  ST_REPEAT: begin
                     if (sts.rep_overrun) begin
                        valid_in = 1'b1; bad_in = 1'b1;
                        cmd.emit_err = 1'b1; state_in = ST_IDLE;
                     end else if (sts.rep_zero) begin
                        cmd.repeat_load = 1'b1;
                        if (sts.flags_full) begin
                           cmd.begin_coords = 1'b1;
                           phase_in = ST_XDELTA; state_in = ST_FREE;
                        end else state_in = ST_FLAGS;
                     end else begin
                        cmd.repeat_load = 1'b1; state_in = ST_FILL;
                     end
                  end
                  ST_XDELTA, ST_YDELTA: begin
                     if (sts.cur_short || sts.hi_pending) begin
                        if (sts.cur_short) cmd.delta_byte = 1'b1;
                        else cmd.delta_word = 1'b1;
                        cmd.close_pt = 1'b1;
                        state_in = ST_FREE;
                        if (!xph) begin
                           valid_in = 1'b1; bad_in = 1'b0;
                           state_in = ST_EMIT;
                           if (sts.last_cursor) phase_in = ST_IDLE;
                        end else if (sts.last_cursor) phase_in = ST_YDELTA;
                     end else cmd.take_high = 1'b1;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         bad_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
         bad_ff <= bad_in;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> !in_ready) else $error("accept during fill");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> valid_ff) else $error("result dropped");
   a_emit_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !in_ready) else $error("accept with result pending");
endmodule
`default_nettype wire

[sv/glyph_outline_point_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_outline_point_decoder
// Decodes the point data of a simple glyph body into absolute points.
// ----------------------------------------------------------------------------
// A point that ends on a byte is offered in the cycle after that byte; a
// point needing no byte is found by a look-ahead step per coordinate.
// Throughput: one byte per cycle in header and flags unless stalled; an x byte
// closing a point adds a look-ahead, a y byte the transfer, then a look-ahead;
// a repeated flag is a fill step, a byte-free point a look-ahead (and a y transfer).
// Reset: synchronous, returns the parser to idle; the stores are not cleared.
module glyph_outline_point_decoder import gopd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // data_byte
   input  wire logic [15:0] req_tuser,  // glyph_start, contour_count
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // x_coord, y_coord, point_number
   output logic [1:0]       rsp_tuser   // last_point, bad_glyph
);
   cmd_type cmd;
   sts_type sts;
   logic signed [15:0] x_coord, y_coord;
   logic [IdxW-1:0] point_number;
   logic last_point, bad;

   gopd_control u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .glyph_start(req_tuser[0]),
      .contour_zero(req_tuser[15:1] == 15'd0), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_bad(bad),
      .sts, .cmd);

   gopd_datapath u_dp (
      .clock, .reset, .cmd, .data_byte(req_tdata),
      .contour_count(req_tuser[15:1]), .sts, .x_coord, .y_coord,
      .point_number, .last_point);

   assign rsp_tdata = {2'b00, point_number, y_coord, x_coord};
   assign rsp_tuser = {bad, last_point};
endmodule
`default_nettype wire

[tb/glyph_point_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_point_checker
// Watches both channels of the glyph point decoder, predicts the points of
// every accepted byte and compares each output transfer in order.
// ----------------------------------------------------------------------------
module glyph_point_checker import gopd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic [15:0] req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   output int               fail_count,
   output int               points_pending
);
   typedef enum logic [2:0] {
      PH_IDLE, PH_ENDPTS, PH_INSTLEN, PH_INSTSKIP, PH_FLAGS, PH_REPEAT,
      PH_XDELTA, PH_YDELTA
   } phase_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [5:0]  num;
      logic        last;
      logic        bad;
   } point_type;

   point_type   expected_points[$];
   phase_type   phase;
   logic [15:0] bytes_left;
   logic        hi_pending;
   logic [7:0]  hi_byte;
   logic [6:0]  total;
   logic [6:0]  cursor;
   logic [5:0]  held;
   logic [15:0] coord;
   logic [5:0]  flags[64];
   logic [15:0] xs[64];

   assign points_pending = expected_points.size();

   task automatic report(input string what);
      $display("mismatch: %s", what);
      fail_count++;
   endtask

   task automatic push_error();
      expected_points.push_back('{16'd0, 16'd0, 6'd0, 1'b0, 1'b1});
      phase = PH_IDLE;
   endtask

   task automatic close_point();
      if (phase == PH_XDELTA) xs[cursor[5:0]] = coord;
      else expected_points.push_back('{xs[cursor[5:0]], coord, cursor[5:0],
                                        cursor + 7'd1 == total, 1'b0});
      cursor++;
      if (cursor >= total) begin
         if (phase == PH_XDELTA) begin
            phase = PH_YDELTA;
            cursor = 0;
            coord = 0;
         end else begin
            phase = PH_IDLE;
         end
      end
   endtask

   // Points whose flag says "same value, no byte" complete immediately.
   task automatic close_free_points();
      logic [5:0] f;
      logic isx;
      while (phase == PH_XDELTA || phase == PH_YDELTA) begin
         isx = phase == PH_XDELTA;
         f = flags[cursor[5:0]];
         if (f[isx ? 1 : 2] || !f[isx ? 4 : 5]) break;
         close_point();
      end
   endtask

   task automatic begin_coords();
      phase = PH_XDELTA;
      cursor = 0;
      coord = 0;
      hi_pending = 0;
      close_free_points();
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic start,
                              input logic [14:0] contours);
      logic [15:0] w;
      logic [5:0] f;
      logic isx;
      if (start) begin
         hi_pending = 0; hi_byte = 0; cursor = 0; total = 0; coord = 0; held = 0;
         bytes_left = {1'b0, contours};
         phase = contours != 0 ? PH_ENDPTS : PH_IDLE;
      end
      w = {hi_byte, b};
      case (phase)
         PH_ENDPTS, PH_INSTLEN: begin
            if (!hi_pending) begin
               hi_byte = b;
               hi_pending = 1;
            end else begin
               hi_pending = 0;
               if (phase == PH_ENDPTS) begin
                  bytes_left--;
                  if (bytes_left == 0) begin
                     if (w >= MaxPoints) push_error();
                     else begin
                        total = w[6:0] + 7'd1;
                        phase = PH_INSTLEN;
                     end
                  end
               end else begin
                  bytes_left = w;
                  cursor = 0;
                  phase = w != 0 ? PH_INSTSKIP : PH_FLAGS;
               end
            end
         end
         PH_INSTSKIP: begin
            bytes_left--;
            if (bytes_left == 0) phase = PH_FLAGS;
         end
         PH_FLAGS: begin
            held = b[5:0];
            flags[cursor[5:0]] = held;
            if (held[3]) phase = PH_REPEAT;
            else begin
               cursor++;
               if (cursor >= total) begin_coords();
            end
         end
         PH_REPEAT: begin
            if (int'(cursor) + int'(b) >= int'(total)) push_error();
            else begin
               for (int r = 1; r <= b; r++) flags[(int'(cursor) + r) % 64] = held;
               cursor = cursor + b[6:0] + 7'd1;
               phase = PH_FLAGS;
               if (cursor >= total) begin_coords();
            end
         end
         PH_XDELTA, PH_YDELTA: begin
            isx = phase == PH_XDELTA;
            f = flags[cursor[5:0]];
            if (f[isx ? 1 : 2]) begin
               coord = f[isx ? 4 : 5] ? coord + {8'd0, b} : coord - {8'd0, b};
               close_point();
               close_free_points();
            end else if (!hi_pending) begin
               hi_byte = b;
               hi_pending = 1;
            end else begin
               coord = coord + w;
               hi_pending = 0;
               close_point();
               close_free_points();
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      point_type got, want;
      if (reset) begin
         phase = PH_IDLE;
         hi_pending = 0;
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[37:32],
                   rsp_tuser[0], rsp_tuser[1]};
            if (expected_points.size() == 0) begin
               report($sformatf("unexpected point %h", got));
            end else begin
               want = expected_points.pop_front();
               if (got.x !== want.x) report($sformatf("x %h want %h", got.x, want.x));
               if (got.y !== want.y) report($sformatf("y %h want %h", got.y, want.y));
               if (got.num !== want.num)
                  report($sformatf("index %0d want %0d", got.num, want.num));
               if (got.last !== want.last) report("last_point flag wrong");
               if (got.bad !== want.bad) report("bad_glyph flag wrong");
            end
         end
         if (req_tvalid && req_tready)
            decode_byte(req_tdata, req_tuser[0], req_tuser[15:1]);
      end
   end
endmodule

[tb/tb_glyph_outline_point_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_outline_point_decoder
// Streams directed and random glyph bodies through the decoder under varying
// back-pressure; a separate checker predicts and compares every point.
// ----------------------------------------------------------------------------
module tb_glyph_outline_point_decoder;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic [15:0] req_tuser = 0;   // glyph_start, contour_count
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;       // x_coord, y_coord, point_number
   logic [1:0]  rsp_tuser;       // last_point, bad_glyph
   int          fail_count;
   int          points_pending;
   int          send_idle_pct = 10;
   int          recv_idle_pct = 85;
   int          quiet_cycles = 0;
   int          bytes_sent = 0;
   logic [7:0]  body[$];

   localparam int WatchdogLimit = 20000;
   localparam int PhaseBytes = 28;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   glyph_outline_point_decoder DUT (.*);

   glyph_point_checker checker_i (.*);

   // The receiver stalls at random, at a rate that changes between phases.
   always @(posedge clock)
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);

   // A watchdog: ends the run if no transfer happens on either side for long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Sends one byte; the first byte of a glyph carries the start flag and the
   // contour count. The sender may idle before the transfer. Valid stays high
   // after the transfer until the next byte or an idle cycle replaces it.
   task automatic send_byte(input logic [7:0] b, input logic start, input logic [14:0] n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {n, start};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_glyph(input logic [14:0] n);
      send_byte(body.pop_front(), 1'b1, n);
      while (body.size() != 0) send_byte(body.pop_front(), 1'b0, 15'd0);
   endtask

   task automatic push_word(input logic [15:0] w);
      body.push_back(w[15:8]);
      body.push_back(w[7:0]);
   endtask

   // Builds a well-formed body with the given contour count and point count.
   // Flags are random, sometimes packed with repeat runs; deltas follow them.
   task automatic build_glyph(input int contours, input int npts, input int ilen,
                              input bit wild);
      logic [7:0] fl[64];
      int i, run;
      for (i = 0; i < contours; i++)
         push_word(16'(i == contours - 1 ? npts - 1 : int'($urandom_range(63))));
      push_word(16'(ilen));
      for (i = 0; i < ilen; i++) body.push_back(8'($urandom_range(255)));
      i = 0;
      while (i < npts) begin
         fl[i] = 8'($urandom_range(255));
         fl[i][3] = 1'b0;
         if ($urandom_range(3) == 0 && i < npts - 1) begin
            run = int'($urandom_range(npts - 1 - i));
            body.push_back(fl[i] | 8'h08);
            body.push_back(8'(run));
            for (int r = 1; r <= run; r++) fl[i + r] = fl[i];
            i += run + 1;
         end else begin
            body.push_back(fl[i]);
            i++;
         end
      end
      for (int axis = 0; axis < 2; axis++)
         for (i = 0; i < npts; i++) begin
            if (fl[i][1 + axis]) body.push_back(8'($urandom_range(255)));
            else if (!fl[i][4 + axis])
               push_word(wild ? 16'($urandom) : 16'($urandom_range(65535)));
         end
      // Trailing bytes after the glyph are ignored.
      if ($urandom_range(3) == 0) body.push_back(8'($urandom_range(255)));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int base;
      int nc;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: idle bytes, zero contours, a single point, the largest
      // glyph, too many points, a repeat overrun and extreme word deltas.
      send_byte(8'hFF, 1'b0, 15'd0);
      body.push_back(8'hAA); body.push_back(8'h55);
      send_glyph(15'd0);
      build_glyph(1, 1, 0, 1'b0); send_glyph(15'd1);
      body.push_back(8'h00); body.push_back(8'h00); push_word(16'd0);
      body.push_back(8'h00); push_word(16'h7FFF); push_word(16'h8000);
      send_glyph(15'd1);
      // Largest glyph: 63 points needing no byte, then one short point.
      push_word(16'd10); push_word(16'd63); push_word(16'd0);
      body.push_back(8'h38); body.push_back(8'd62); body.push_back(8'h06);
      body.push_back(8'h81); body.push_back(8'h7F);
      send_glyph(15'd2);
      push_word(16'hFFFF); push_word(16'd64); send_glyph(15'd2);
      push_word(16'd63); send_glyph(15'd1);
      push_word(16'd3); push_word(16'd0); body.push_back(8'h08); body.push_back(8'd4);
      send_glyph(15'd1);
      // A repeat that exactly fills the glyph, left without its deltas.
      push_word(16'd5); push_word(16'd0); body.push_back(8'h3F); body.push_back(8'd5);
      send_glyph(15'd1);
      // The largest contour count.
      body.push_back(8'h00); send_glyph(15'h7FFF);
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle_pct = 85; recv_idle_pct = 10; end
         if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         base = bytes_sent;
         while (bytes_sent - base < PhaseBytes) begin
            case ($urandom_range(9))
               0: begin
                  // Broken glyph: random bytes.
                  repeat ($urandom_range(1, 12)) body.push_back(8'($urandom_range(255)));
                  send_glyph(15'($urandom_range(1, 4)));
               end
               1: begin
                  push_word(16'($urandom_range(64, 65535)));
                  send_glyph(15'd1);
               end
               default: begin
                  nc = int'($urandom_range(1, 3));
                  build_glyph(nc, int'($urandom_range(1, 8)), int'($urandom_range(3)),
                              1'b1);
                  send_glyph(15'(nc));
               end
            endcase
         end
         wait_drained();
      end

      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

[glyph_outline_point_decoder.f]
sv/gopd_pkg.sv
sv/gopd_datapath.sv
sv/gopd_control.sv
sv/glyph_outline_point_decoder.sv
tb/glyph_point_checker.sv
tb/tb_glyph_outline_point_decoder.sv
